### rtl/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, codes and the init event table for the 4-bit LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_DATA  = 3'd1,
    OP_CMD   = 3'd2,
    OP_LINE1 = 3'd3,
    OP_LINE2 = 3'd4,
    OP_CLEAR = 3'd5
  } lcd4_op_e;

  // Fixed command bytes and address bases
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [3:0] LineOneBase = 4'h8;
  localparam logic [3:0] LineTwoBase = 4'hC;

  // Short waits in ms (fit the descriptor fields)
  localparam logic [1:0] WaitNone  = 2'd0;
  localparam logic [1:0] WaitShort = 2'd1;
  localparam logic [1:0] WaitCmd   = 2'd2;

  // Event index counter
  localparam int unsigned    EvtIdxW     = 5;
  localparam logic [EvtIdxW-1:0] InitLastIdx = 5'd29;
  localparam logic [EvtIdxW-1:0] ByteLastIdx = 5'd4;

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Classified request
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data_byte;
    logic [1:0] tail_wait;
    logic [1:0] final_wait;
  } lcd4_desc_t;

  // One pin event
  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] nibble;
    logic [4:0] wait_ms;
    logic       last_event;
  } lcd4_evt_t;

  // Power-on init sequence: clear pins, wake-up nibbles, setup bytes
  // 0x28 0x08 0x01 0x06 0x0C, then raise RS.
  function automatic lcd4_evt_t init_event(logic [EvtIdxW-1:0] idx);
    lcd4_evt_t ev;
    ev.reg_select = 1'b0;
    ev.enable_pin = idx[0];
    ev.nibble     = 4'h0;
    ev.wait_ms    = 5'd1;
    ev.last_event = 1'b0;
    unique case (idx)
      5'd0:                      ev.wait_ms = 5'd20;
      5'd1, 5'd3, 5'd4,
      5'd5, 5'd6:                ev.nibble  = 4'h3;
      5'd2: begin
        ev.nibble  = 4'h3;
        ev.wait_ms = 5'd6;
      end
      5'd7, 5'd8, 5'd9, 5'd10:   ev.nibble  = 4'h2;
      5'd11, 5'd15:              ev.nibble  = 4'h8;
      5'd12, 5'd16: begin
        ev.nibble  = 4'h8;
        ev.wait_ms = 5'd0;
      end
      5'd13, 5'd14, 5'd17, 5'd18,
      5'd21, 5'd22, 5'd25, 5'd26: ev.nibble  = 4'h0;
      5'd19:                     ev.nibble  = 4'h1;
      5'd20: begin
        ev.nibble  = 4'h1;
        ev.wait_ms = 5'd2;
      end
      5'd23:                     ev.nibble  = 4'h6;
      5'd24: begin
        ev.nibble  = 4'h6;
        ev.wait_ms = 5'd0;
      end
      5'd27:                     ev.nibble  = 4'hC;
      5'd28: begin
        ev.nibble  = 4'hC;
        ev.wait_ms = 5'd0;
      end
      default: begin
        // final event, RS back high
        ev.reg_select = 1'b1;
        ev.enable_pin = 1'b0;
        ev.nibble     = 4'hC;
        ev.wait_ms    = 5'd0;
        ev.last_event = 1'b1;
      end
    endcase
    return ev;
  endfunction

endpackage

### rtl/lcd4_req_if.sv
// ----------------------------------------------------------------------------
// lcd4_req_if
// Request channel: one word per LCD request.
// ----------------------------------------------------------------------------
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] value;
  logic [3:0] position;

  modport source (output valid, output opcode, output value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input value, input position,
                  output ready);
endinterface

### rtl/lcd4_evt_if.sv
// ----------------------------------------------------------------------------
// lcd4_evt_if
// Event channel: one word per LCD pin event.
// ----------------------------------------------------------------------------
interface lcd4_evt_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       enable_pin;
  logic [3:0] nibble;
  logic [4:0] wait_ms;
  logic       last_event;

  modport source (output valid, output reg_select, output enable_pin,
                  output nibble, output wait_ms, output last_event,
                  input ready);
  modport sink   (input valid, input reg_select, input enable_pin,
                  input nibble, input wait_ms, input last_event,
                  output ready);
endinterface

### rtl/lcd4_front.sv
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts request words and classifies them into sequencer descriptors.
// ----------------------------------------------------------------------------
module lcd4_front (
  lcd4_req_if.sink          req_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lcd4_pkg::lcd4_desc_t desc_o
);

  logic known;

  assign req_i.ready = ~q_full_i;

  // Opcode decode
  always_comb begin
    known            = 1'b1;
    desc_o.is_init    = 1'b0;
    desc_o.rs         = 1'b0;
    desc_o.data_byte  = req_i.value;
    desc_o.tail_wait  = lcd4_pkg::WaitCmd;
    desc_o.final_wait = lcd4_pkg::WaitNone;
    unique case (lcd4_pkg::lcd4_op_e'(req_i.opcode))
      lcd4_pkg::OP_INIT:  desc_o.is_init = 1'b1;
      lcd4_pkg::OP_DATA: begin
        desc_o.rs        = 1'b1;
        desc_o.tail_wait = lcd4_pkg::WaitNone;
      end
      lcd4_pkg::OP_CMD:   desc_o.tail_wait = lcd4_pkg::WaitCmd;
      lcd4_pkg::OP_LINE1: begin
        desc_o.data_byte  = {lcd4_pkg::LineOneBase, req_i.position};
        desc_o.final_wait = lcd4_pkg::WaitShort;
      end
      lcd4_pkg::OP_LINE2: begin
        desc_o.data_byte  = {lcd4_pkg::LineTwoBase, req_i.position};
        desc_o.final_wait = lcd4_pkg::WaitShort;
      end
      lcd4_pkg::OP_CLEAR: begin
        desc_o.data_byte  = lcd4_pkg::CmdClear;
        desc_o.final_wait = lcd4_pkg::WaitCmd;
      end
      default:            known = 1'b0;
    endcase
  end

  // Unknown requests are taken and dropped
  assign push_o = req_i.valid & req_i.ready & known;

endmodule

### rtl/lcd4_queue.sv
// ----------------------------------------------------------------------------
// lcd4_queue
// Short descriptor queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module lcd4_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcd4_pkg::lcd4_desc_t din_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output lcd4_pkg::lcd4_desc_t head_o
);

  lcd4_pkg::lcd4_desc_t         mem_q [lcd4_pkg::QDepth];
  logic [lcd4_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lcd4_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lcd4_pkg::QPtrW:0]     count_q, count_d;

  assign full_o       = (count_q == (lcd4_pkg::QPtrW+1)'(lcd4_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == lcd4_pkg::QPtrW'(lcd4_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == lcd4_pkg::QPtrW'(lcd4_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue popped while empty");
`endif

endmodule

### rtl/lcd4_seq.sv
// ----------------------------------------------------------------------------
// lcd4_seq
// Walks the queue head through its pin events, one event word per cycle
// while the receiver is ready, into an output register.
// ----------------------------------------------------------------------------
module lcd4_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  lcd4_pkg::lcd4_desc_t head_i,
  output logic                 pop_o,
  lcd4_evt_if.source           evt_o
);

  logic [lcd4_pkg::EvtIdxW-1:0] idx_q, idx_d;
  logic                         out_valid_q, out_valid_d;
  lcd4_pkg::lcd4_evt_t          out_q, ev;
  logic                         load;

  // Event for the current head and index
  always_comb begin
    if (head_i.is_init) begin
      ev = lcd4_pkg::init_event(idx_q);
    end else begin
      ev.reg_select = head_i.rs;
      ev.enable_pin = (idx_q == 5'd0) || (idx_q == 5'd2);
      ev.nibble     = (idx_q < 5'd2) ? head_i.data_byte[7:4] : head_i.data_byte[3:0];
      ev.wait_ms    = 5'd1;
      ev.last_event = 1'b0;
      if (idx_q == 5'd3) begin
        ev.wait_ms = {3'b000, head_i.tail_wait};
      end else if (idx_q >= lcd4_pkg::ByteLastIdx) begin
        // closing event flips RS
        ev.reg_select = ~head_i.rs;
        ev.wait_ms    = {3'b000, head_i.final_wait};
        ev.last_event = 1'b1;
      end
    end
  end

  // Output register takes a new word when empty or drained
  assign load  = head_valid_i && (!out_valid_q || evt_o.ready);
  assign pop_o = load && ev.last_event;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = ev.last_event ? '0 : idx_q + 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= ev;
    end
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.reg_select = out_q.reg_select;
  assign evt_o.enable_pin = out_q.enable_pin;
  assign evt_o.nibble     = out_q.nibble;
  assign evt_o.wait_ms    = out_q.wait_ms;
  assign evt_o.last_event = out_q.last_event;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= lcd4_pkg::InitLastIdx) else $error("event index out of range");
  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && !head_i.is_init) |-> idx_q <= lcd4_pkg::ByteLastIdx)
    else $error("byte request index out of range");
  a_idx_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0) else $error("index not rewound after request");
`endif

endmodule

### rtl/char_lcd_4bit_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_top
// Turns character-LCD requests into ordered 4-bit bus pin events.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request word (opcode, value, position) per handshake.
//   evt_o carries one pin event word per handshake: RS, EN, D7..D4 levels
//   and the hold time in ms; last_event marks the end of a request.
//   Init gives 30 event words; data, command, line address and clear give
//   5 each; opcodes 6 and 7 are taken and give nothing.
// Flow: the first event word passes through the request queue and the
//   output register before it is presented. After that the sequencer emits
//   one event word per cycle while the receiver is ready; the event counter
//   stepping through the head request sets this rate.
// A two-entry request queue lets new requests be taken while earlier ones
//   are still being sequenced; req_i.ready drops only when it is full.
// When the receiver stalls, the output register holds its word and the
//   sequencer waits; requests still fill the queue.
// Reset (asynchronous, active low) empties the queue and the output stage.
// ----------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcd4_req_if.sink   req_i,
  lcd4_evt_if.source evt_o
);

  logic                 push, q_full, pop, head_valid;
  lcd4_pkg::lcd4_desc_t desc, head;

  lcd4_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (desc)
  );

  lcd4_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .din_i        (desc),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lcd4_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .evt_o        (evt_o)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4-bit character-LCD command sequencer. A
// queue-fed driver offers requests with random gaps. Each accepted request is
// expanded locally into its list of pin event words. A monitor compares every
// event word that leaves the block, field by field, against that list. The
// receiver stalls at random and, now and then, holds off for a long stretch
// so that the request queue fills and back-pressures the driver.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit     = 2_000_000;
  localparam int unsigned RandomRequests = 300;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned FirstHoldAt    = 40;
  localparam int unsigned HoldSpacing    = 1000;

  // Opcodes past the defined set: taken, no events
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // Init wake-up nibbles and setup bytes
  localparam logic [3:0] WakeNibble    = 4'h3;
  localparam logic [3:0] Mode4Nibble   = 4'h2;
  localparam logic [7:0] CmdFuncSet4b  = 8'h28;
  localparam logic [7:0] CmdDisplayOff = 8'h08;
  localparam logic [7:0] CmdEntryMode  = 8'h06;
  localparam logic [7:0] CmdDisplayOn  = 8'h0C;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic [3:0] position;
  } lcd_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcd4_req_if req_if ();
  lcd4_evt_if evt_if ();

  char_lcd_4bit_command_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .evt_o  (evt_if)
  );

  lcd_req_t             requests_pending[$];
  lcd4_pkg::lcd4_evt_t  pin_events_due[$];
  int unsigned          words_seen;
  int unsigned          mismatches = 0;
  logic                 rx_hold;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Event list prediction
  // ------------------------------------------------------------------
  function automatic void add_event(logic rs, logic en, logic [3:0] nib,
                                    logic [4:0] hold_ms, logic last);
    lcd4_pkg::lcd4_evt_t ev;
    ev.reg_select = rs;
    ev.enable_pin = en;
    ev.nibble     = nib;
    ev.wait_ms    = hold_ms;
    ev.last_event = last;
    pin_events_due.push_back(ev);
  endfunction

  // EN high for 1 ms, then EN low with the nibble held
  function automatic void add_strobe(logic rs, logic [3:0] nib, logic [4:0] low_ms);
    add_event(rs, 1'b1, nib, 5'd1, 1'b0);
    add_event(rs, 1'b0, nib, low_ms, 1'b0);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b, logic [4:0] tail_ms);
    add_strobe(rs, b[7:4], 5'd1);
    add_strobe(rs, b[3:0], tail_ms);
  endfunction

  // Command byte, 2 ms settle, then RS back high
  function automatic void add_command(logic [7:0] b, logic [4:0] final_ms);
    add_byte(1'b0, b, 5'd2);
    add_event(1'b1, 1'b0, b[3:0], final_ms, 1'b1);
  endfunction

  function automatic void predict_pin_events(lcd_req_t r);
    case (r.opcode)
      lcd4_pkg::OP_INIT: begin
        add_event(1'b0, 1'b0, 4'h0, 5'd20, 1'b0);
        add_strobe(1'b0, WakeNibble, 5'd6);
        add_strobe(1'b0, WakeNibble, 5'd1);
        add_strobe(1'b0, WakeNibble, 5'd1);
        add_strobe(1'b0, Mode4Nibble, 5'd1);
        add_byte(1'b0, CmdFuncSet4b, 5'd0);
        add_byte(1'b0, CmdDisplayOff, 5'd0);
        add_byte(1'b0, lcd4_pkg::CmdClear, 5'd2);
        add_byte(1'b0, CmdEntryMode, 5'd0);
        add_byte(1'b0, CmdDisplayOn, 5'd0);
        add_event(1'b1, 1'b0, CmdDisplayOn[3:0], 5'd0, 1'b1);
      end
      lcd4_pkg::OP_DATA: begin
        add_byte(1'b1, r.value, 5'd0);
        add_event(1'b0, 1'b0, r.value[3:0], 5'd0, 1'b1);
      end
      lcd4_pkg::OP_CMD:   add_command(r.value, 5'd0);
      lcd4_pkg::OP_LINE1: add_command({lcd4_pkg::LineOneBase, r.position}, 5'd1);
      lcd4_pkg::OP_LINE2: add_command({lcd4_pkg::LineTwoBase, r.position}, 5'd1);
      lcd4_pkg::OP_CLEAR: add_command(lcd4_pkg::CmdClear, 5'd2);
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and runs with none at all
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void queue_request(logic [2:0] op, logic [7:0] val, logic [3:0] pos);
    lcd_req_t r;
    r.opcode   = op;
    r.value    = val;
    r.position = pos;
    requests_pending.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [4:0] due, logic [4:0] got);
    if (got !== due) begin
      $error("%s: expected %0d, got %0d", name, due, got);
      mismatches++;
    end
  endfunction

  // ------------------------------------------------------------------
  // Request driver
  // ------------------------------------------------------------------
  int unsigned req_gap;
  int unsigned req_calm;

  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    lcd_req_t next_req;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.opcode   <= '0;
      req_if.value    <= '0;
      req_if.position <= '0;
      req_gap  = 0;
      req_calm = 0;
    end else begin
      if (req_if.valid && req_if.ready)
        predict_pin_events({req_if.opcode, req_if.value, req_if.position});
      // hold the word until taken
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          next_req = requests_pending.pop_front();
          req_if.valid    <= 1'b1;
          req_if.opcode   <= next_req.opcode;
          req_if.value    <= next_req.value;
          req_if.position <= next_req.position;
          req_gap = pick_gap(req_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Long receiver hold-off, counted here
  // ------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned next_hold_at;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold <= 1'b0;
      hold_left    = 0;
      next_hold_at = FirstHoldAt;
    end else if (hold_left > 0) begin
      hold_left--;
      rx_hold <= (hold_left != 0);
    end else if (words_seen >= next_hold_at) begin
      hold_left    = HoldCycles;
      next_hold_at = next_hold_at + HoldSpacing;
      rx_hold <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // Receiver ready with random stalls
  // ------------------------------------------------------------------
  int unsigned rx_stall;
  int unsigned rx_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_if.ready <= 1'b0;
      rx_stall = 0;
      rx_calm  = 0;
    end else if (rx_hold) begin
      evt_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= 1'b1;
      rx_stall = pick_gap(rx_calm);
    end
  end

  // ------------------------------------------------------------------
  // Event word monitor
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_evt
    lcd4_pkg::lcd4_evt_t due;
    if (!rst_ni) begin
      words_seen <= 0;
    end else if (evt_if.valid && evt_if.ready) begin
      words_seen <= words_seen + 1;
      if (pin_events_due.size() == 0) begin
        $error("unexpected event word: rs %0d en %0d nibble %0h wait %0d last %0d",
               evt_if.reg_select, evt_if.enable_pin, evt_if.nibble,
               evt_if.wait_ms, evt_if.last_event);
        mismatches++;
      end else begin
        due = pin_events_due.pop_front();
        check_field("reg_select", 5'(due.reg_select), 5'(evt_if.reg_select));
        check_field("enable_pin", 5'(due.enable_pin), 5'(evt_if.enable_pin));
        check_field("nibble",     5'(due.nibble),     5'(evt_if.nibble));
        check_field("wait_ms",    due.wait_ms,        evt_if.wait_ms);
        check_field("last_event", 5'(due.last_event), 5'(evt_if.last_event));
      end
    end
  end

  // ------------------------------------------------------------------
  // Run limit
  // ------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("char_lcd_4bit_command_sequencer_top verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------
  initial begin : stimulus
    int unsigned taken;
    int unsigned r;
    logic [2:0]  op;

    rst_ni = 1'b0;

    // Directed: every opcode, byte and column extremes, spare opcodes
    queue_request(lcd4_pkg::OP_INIT,  8'($urandom), 4'($urandom));
    queue_request(lcd4_pkg::OP_DATA,  8'h00, 4'hF);
    queue_request(lcd4_pkg::OP_DATA,  8'hFF, 4'h0);
    queue_request(lcd4_pkg::OP_DATA,  8'hA5, 4'($urandom));
    queue_request(lcd4_pkg::OP_CMD,   8'h00, 4'hF);
    queue_request(lcd4_pkg::OP_CMD,   8'hFF, 4'h0);
    queue_request(lcd4_pkg::OP_CMD,   8'h5A, 4'($urandom));
    queue_request(lcd4_pkg::OP_LINE1, 8'hFF, 4'h0);
    queue_request(lcd4_pkg::OP_LINE1, 8'h00, 4'hF);
    queue_request(lcd4_pkg::OP_LINE2, 8'hFF, 4'h0);
    queue_request(lcd4_pkg::OP_LINE2, 8'h00, 4'hF);
    queue_request(lcd4_pkg::OP_CLEAR, 8'hFF, 4'hF);
    queue_request(OpSpare6, 8'hFF, 4'hF);
    queue_request(OpSpare7, 8'h00, 4'h0);
    queue_request(lcd4_pkg::OP_DATA,  8'h3C, 4'($urandom));
    queue_request(OpSpare7, 8'($urandom), 4'($urandom));
    queue_request(lcd4_pkg::OP_INIT,  8'hFF, 4'hF);
    queue_request(lcd4_pkg::OP_CLEAR, 8'h00, 4'h0);
    queue_request(lcd4_pkg::OP_LINE2, 8'($urandom), 4'h9);

    // Random: init now and then, spare opcodes rarely, the rest uniform
    taken = 0;
    while (taken < RandomRequests) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        op = lcd4_pkg::OP_INIT;
      end else if (r < 10) begin
        op = ($urandom_range(0, 1) != 0) ? OpSpare7 : OpSpare6;
      end else begin
        op = 3'($urandom_range(lcd4_pkg::OP_DATA, lcd4_pkg::OP_CLEAR));
      end
      queue_request(op, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      if (op != OpSpare6 && op != OpSpare7) taken++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_pending.size() != 0 || req_if.valid) @(posedge clk_i);
    while (pin_events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("char_lcd_4bit_command_sequencer_top verification clean");
    end else begin
      $display("char_lcd_4bit_command_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
